/* sv/bbcl_pkg.sv */
package bbcl_pkg;

    // Fraction bits of the gain registers.
    localparam int BBCL_GAIN_FRAC_BITS = 16;

    // Datapath widths.
    localparam int BBCL_MUL_W  = 33;
    localparam int BBCL_PROD_W = 2 * BBCL_MUL_W;
    localparam int BBCL_ACC_W  = 68;
    localparam int BBCL_STEP_W = 4;
    localparam int BBCL_CFG_IDX_W = 8;

    // Reciprocal of 5 scaled by 2^34, rounded up; exact for magnitudes below 2^34.
    localparam logic [31:0] BBCL_DIV5_RECIP = 32'd3435973837;
    localparam int          BBCL_DIV5_SHIFT = 34;

    // Integral clamp: 10000 counts with 12 fraction bits.
    localparam logic signed [32:0] BBCL_INTEG_MAX = 33'sd40960000;
    localparam logic signed [32:0] BBCL_INTEG_MIN = -33'sd40960000;

    // Register indexes of the configuration port.
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_BAL_KP         = 8'd0;
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_BAL_KD         = 8'd1;
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_SPEED_KP       = 8'd2;
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_SPEED_KI       = 8'd3;
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_TURN_KP        = 8'd4;
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_TURN_KD        = 8'd5;
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_BALANCE_OFFSET = 8'd6;
    localparam logic [BBCL_CFG_IDX_W-1:0] CFG_TILT_LIMIT     = 8'd7;

    // Register reset values.
    localparam logic signed [31:0] RST_BAL_KP         = 32'sd27852800;
    localparam logic signed [31:0] RST_BAL_KD         = 32'sd131072;
    localparam logic signed [31:0] RST_SPEED_KP       = -32'sd3735552;
    localparam logic signed [31:0] RST_SPEED_KI       = -32'sd18350;
    localparam logic signed [31:0] RST_TURN_KP        = 32'sd983040;
    localparam logic signed [31:0] RST_TURN_KD        = 32'sd9830;
    localparam logic signed [16:0] RST_BALANCE_OFFSET = 17'sd0;
    localparam logic [15:0]        RST_TILT_LIMIT     = 16'd7680;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic signed [31:0] bal_kp;
        logic signed [31:0] bal_kd;
        logic signed [31:0] speed_kp;
        logic signed [31:0] speed_ki;
        logic signed [31:0] turn_kp;
        logic signed [31:0] turn_kd;
        logic signed [16:0] balance_offset;
        logic [15:0]        tilt_limit;
    } bbcl_cfg_t;

    // Multiplier operand A sources.
    typedef enum logic [2:0] {
        MA_BIAS,
        MA_TILT,
        MA_NUM,
        MA_TURN,
        MA_YAW,
        MA_FILT,
        MA_INTEG
    } bbcl_mula_t;

    // Multiplier operand B sources.
    typedef enum logic [2:0] {
        MB_BKP,
        MB_BKD,
        MB_RECIP,
        MB_TKP,
        MB_TKD,
        MB_SKP,
        MB_SKI
    } bbcl_mulb_t;

    // Accumulator operations.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SHL8,
        ACC_SUB,
        ACC_ROUND
    } bbcl_acc_op_t;

    // Which drive term a rounding or write step works on.
    typedef enum logic [1:0] {
        TERM_BAL,
        TERM_SPD,
        TERM_TRN
    } bbcl_term_t;

    // Jump conditions of the sequencer.
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_OUT_BUSY
    } bbcl_cond_t;

    // Control word that drives the datapath.
    typedef struct packed {
        logic         capture;
        logic         mul_en;
        bbcl_mula_t   mula;
        bbcl_mulb_t   mulb;
        bbcl_acc_op_t acc_op;
        bbcl_term_t   term;
        logic         write_term;
        logic         filt_prep;
        logic         filt_div;
        logic         integ_upd;
        logic         integ_clr;
        logic         out_load;
    } bbcl_ctrl_t;

    // One microcode word: datapath control plus the jump.
    typedef struct packed {
        bbcl_ctrl_t             ctrl;
        bbcl_cond_t             cond;
        logic [BBCL_STEP_W-1:0] target;
    } bbcl_uword_t;

    // Named steps used as jump targets.
    localparam logic [BBCL_STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [BBCL_STEP_W-1:0] ST_WAIT   = 4'd12;

    // Microprogram for one control tick.
    function automatic bbcl_uword_t bbcl_urom(input logic [BBCL_STEP_W-1:0] step);
        bbcl_uword_t w;
        begin
            w = '0;
            case (step)
                // Wait for an input word.
                4'd0:
                begin
                    w.cond   = COND_NO_IN;
                    w.target = ST_IDLE;
                end
                // Balance P product; filter numerator and tilt check.
                4'd1:
                begin
                    w.ctrl.mul_en    = 1'b1;
                    w.ctrl.mula      = MA_BIAS;
                    w.ctrl.mulb      = MB_BKP;
                    w.ctrl.filt_prep = 1'b1;
                end
                4'd2:
                begin
                    w.ctrl.mul_en = 1'b1;
                    w.ctrl.mula   = MA_TILT;
                    w.ctrl.mulb   = MB_BKD;
                    w.ctrl.acc_op = ACC_LOAD;
                end
                // Divide the filter numerator by 5.
                4'd3:
                begin
                    w.ctrl.mul_en = 1'b1;
                    w.ctrl.mula   = MA_NUM;
                    w.ctrl.mulb   = MB_RECIP;
                    w.ctrl.acc_op = ACC_ADD_SHL8;
                end
                4'd4:
                begin
                    w.ctrl.mul_en   = 1'b1;
                    w.ctrl.mula     = MA_TURN;
                    w.ctrl.mulb     = MB_TKP;
                    w.ctrl.acc_op   = ACC_ROUND;
                    w.ctrl.term     = TERM_BAL;
                    w.ctrl.filt_div = 1'b1;
                end
                4'd5:
                begin
                    w.ctrl.mul_en     = 1'b1;
                    w.ctrl.mula       = MA_YAW;
                    w.ctrl.mulb       = MB_TKD;
                    w.ctrl.acc_op     = ACC_LOAD;
                    w.ctrl.term       = TERM_BAL;
                    w.ctrl.write_term = 1'b1;
                    w.ctrl.integ_upd  = 1'b1;
                end
                4'd6:
                begin
                    w.ctrl.mul_en = 1'b1;
                    w.ctrl.mula   = MA_FILT;
                    w.ctrl.mulb   = MB_SKP;
                    w.ctrl.acc_op = ACC_SUB;
                end
                4'd7:
                begin
                    w.ctrl.acc_op = ACC_ROUND;
                    w.ctrl.term   = TERM_TRN;
                end
                4'd8:
                begin
                    w.ctrl.mul_en     = 1'b1;
                    w.ctrl.mula       = MA_INTEG;
                    w.ctrl.mulb       = MB_SKI;
                    w.ctrl.acc_op     = ACC_LOAD;
                    w.ctrl.term       = TERM_TRN;
                    w.ctrl.write_term = 1'b1;
                end
                4'd9:
                begin
                    w.ctrl.acc_op = ACC_ADD;
                end
                4'd10:
                begin
                    w.ctrl.acc_op = ACC_ROUND;
                    w.ctrl.term   = TERM_SPD;
                end
                // Speed term done; the integral may now be cleared.
                4'd11:
                begin
                    w.ctrl.term       = TERM_SPD;
                    w.ctrl.write_term = 1'b1;
                    w.ctrl.integ_clr  = 1'b1;
                end
                // Hold until the output register is free.
                4'd12:
                begin
                    w.cond   = COND_OUT_BUSY;
                    w.target = ST_WAIT;
                end
                4'd13:
                begin
                    w.ctrl.out_load = 1'b1;
                    w.cond          = COND_ALWAYS;
                    w.target        = ST_IDLE;
                end
                default:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = ST_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* sv/bbcl_useq.sv */
module bbcl_useq
    import bbcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_busy,
    output logic       idle,
    output bbcl_ctrl_t ctrl
);

    logic [BBCL_STEP_W-1:0] pc_reg;
    logic [BBCL_STEP_W-1:0] pc_next;
    bbcl_uword_t            uword;
    logic                   jump;

    // Fetch the control word of the current step.
    assign uword = bbcl_urom(pc_reg);
    assign idle  = (pc_reg == ST_IDLE);

    // Evaluate the jump condition.
    always_comb
    begin
        case (uword.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_IN:    jump = ~in_valid;
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
    end

    // Next step: jump target or fall through.
    always_comb
    begin
        if (jump)
        begin
            pc_next = uword.target;
        end
        else
        begin
            pc_next = pc_reg + BBCL_STEP_W'(1);
        end
    end

    // Control word out; the input word is captured in the idle step.
    always_comb
    begin
        ctrl         = uword.ctrl;
        ctrl.capture = idle & in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* sv/bbcl_datapath.sv */
module bbcl_datapath
    import bbcl_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = BBCL_GAIN_FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bbcl_ctrl_t          ctrl,
    input  bbcl_cfg_t           cfg,
    input  logic signed [16:0]  angle,
    input  logic signed [15:0]  tilt_rate,
    input  logic signed [15:0]  yaw_rate,
    input  logic signed [15:0]  left_count,
    input  logic signed [15:0]  right_count,
    input  logic signed [15:0]  speed_target,
    input  logic signed [15:0]  turn_target,
    input  logic                out_stall,
    output logic                out_busy,
    output logic                out_valid,
    output logic signed [31:0]  balance_drive,
    output logic signed [31:0]  speed_drive,
    output logic signed [31:0]  turn_drive,
    output logic                motors_off
);

    // Scaling of each drive term.
    localparam int SH_BAL = GAIN_FRAC_BITS + 8;
    localparam int SH_SPD = GAIN_FRAC_BITS + 12;
    localparam int SH_TRN = GAIN_FRAC_BITS;
    localparam logic signed [BBCL_ACC_W-1:0] MASK_BAL =
        (BBCL_ACC_W'(1) <<< SH_BAL) - BBCL_ACC_W'(1);
    localparam logic signed [BBCL_ACC_W-1:0] MASK_SPD =
        (BBCL_ACC_W'(1) <<< SH_SPD) - BBCL_ACC_W'(1);
    localparam logic signed [BBCL_ACC_W-1:0] MASK_TRN =
        (BBCL_ACC_W'(1) <<< SH_TRN) - BBCL_ACC_W'(1);
    localparam logic signed [BBCL_ACC_W-1:0] SAT_HI =
        {{(BBCL_ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [BBCL_ACC_W-1:0] SAT_LO =
        {{(BBCL_ACC_W-31){1'b1}}, {31{1'b0}}};

    // Captured input word.
    logic signed [16:0] angle_reg,  angle_next;
    logic signed [15:0] tilt_reg,   tilt_next;
    logic signed [15:0] yaw_reg,    yaw_next;
    logic signed [15:0] left_reg,   left_next;
    logic signed [15:0] right_reg,  right_next;
    logic signed [15:0] spdt_reg,   spdt_next;
    logic signed [15:0] turnt_reg,  turnt_next;

    // Arithmetic registers.
    logic signed [BBCL_PROD_W-1:0] prod_reg, prod_next;
    logic signed [BBCL_ACC_W-1:0]  acc_reg,  acc_next;
    logic [31:0]                   num_abs_reg, num_abs_next;
    logic                          num_neg_reg, num_neg_next;
    logic                          off_reg, off_next;

    // Loop state. The filter output stays within 4096 times the largest error,
    // below 2^29, so 32 bits hold it.
    logic signed [31:0] filt_reg,  filt_next;
    logic signed [31:0] integ_reg, integ_next;

    // Finished terms and the output register.
    logic signed [31:0] bal_stage_reg, bal_stage_next;
    logic signed [31:0] spd_stage_reg, spd_stage_next;
    logic signed [31:0] trn_stage_reg, trn_stage_next;
    logic signed [31:0] bal_out_reg,   bal_out_next;
    logic signed [31:0] spd_out_reg,   spd_out_next;
    logic signed [31:0] trn_out_reg,   trn_out_next;
    logic               off_out_reg,   off_out_next;
    logic               out_valid_reg, out_valid_next;

    // Combinational values.
    logic signed [17:0]            bias;
    logic signed [17:0]            err;
    logic signed [33:0]            num;
    logic signed [33:0]            num_mag;
    logic [16:0]                   abs_angle;
    logic signed [BBCL_MUL_W-1:0]  mul_a;
    logic signed [BBCL_MUL_W-1:0]  mul_b;
    logic signed [BBCL_PROD_W-1:0] prod_full;
    logic signed [BBCL_ACC_W-1:0]  prod_ext;
    logic signed [BBCL_ACC_W-1:0]  round_mask;
    logic signed [BBCL_ACC_W-1:0]  shifted;
    logic signed [31:0]            term_sat;
    logic signed [31:0]            quot;
    logic signed [32:0]            integ_sum;
    logic signed [31:0]            integ_clamped;

    // Operand preparation.
    assign bias      = 18'(angle_reg) - 18'(cfg.balance_offset);
    assign err       = 18'(left_reg) + 18'(right_reg) - 18'(spdt_reg);
    assign num       = (34'(filt_reg) <<< 2) + (34'(err) <<< 12);
    assign num_mag   = num[33] ? -num : num;
    assign abs_angle = angle_reg[16] ? 17'(-angle_reg) : 17'(angle_reg);

    // Multiplier operand A.
    always_comb
    begin
        case (ctrl.mula)
            MA_BIAS:  mul_a = BBCL_MUL_W'(bias);
            MA_TILT:  mul_a = BBCL_MUL_W'(tilt_reg);
            MA_NUM:   mul_a = {1'b0, num_abs_reg};
            MA_TURN:  mul_a = BBCL_MUL_W'(turnt_reg);
            MA_YAW:   mul_a = BBCL_MUL_W'(yaw_reg);
            MA_FILT:  mul_a = BBCL_MUL_W'(filt_reg);
            MA_INTEG: mul_a = BBCL_MUL_W'(integ_reg);
            default:  mul_a = '0;
        endcase
    end

    // Multiplier operand B.
    always_comb
    begin
        case (ctrl.mulb)
            MB_BKP:   mul_b = BBCL_MUL_W'(cfg.bal_kp);
            MB_BKD:   mul_b = BBCL_MUL_W'(cfg.bal_kd);
            MB_RECIP: mul_b = {1'b0, BBCL_DIV5_RECIP};
            MB_TKP:   mul_b = BBCL_MUL_W'(cfg.turn_kp);
            MB_TKD:   mul_b = BBCL_MUL_W'(cfg.turn_kd);
            MB_SKP:   mul_b = BBCL_MUL_W'(cfg.speed_kp);
            MB_SKI:   mul_b = BBCL_MUL_W'(cfg.speed_ki);
            default:  mul_b = '0;
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod_ext  = BBCL_ACC_W'(prod_reg);

    // Rounding bias and final scaling of the selected term.
    always_comb
    begin
        case (ctrl.term)
            TERM_BAL:
            begin
                round_mask = MASK_BAL;
                shifted    = acc_reg >>> SH_BAL;
            end
            TERM_SPD:
            begin
                round_mask = MASK_SPD;
                shifted    = acc_reg >>> SH_SPD;
            end
            TERM_TRN:
            begin
                round_mask = MASK_TRN;
                shifted    = acc_reg >>> SH_TRN;
            end
            default:
            begin
                round_mask = '0;
                shifted    = '0;
            end
        endcase
    end

    // Saturate the scaled term to 32 bits.
    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            term_sat = SAT_HI[31:0];
        end
        else if (shifted < SAT_LO)
        begin
            term_sat = SAT_LO[31:0];
        end
        else
        begin
            term_sat = shifted[31:0];
        end
    end

    // Quotient magnitude of the filter division; the numerator's sign is restored when the filter is written.
    assign quot = prod_reg[BBCL_DIV5_SHIFT+31:BBCL_DIV5_SHIFT];

    // Integral update with clamp.
    assign integ_sum = 33'(integ_reg) + 33'(filt_reg);
    always_comb
    begin
        if (integ_sum > BBCL_INTEG_MAX)
        begin
            integ_clamped = BBCL_INTEG_MAX[31:0];
        end
        else if (integ_sum < BBCL_INTEG_MIN)
        begin
            integ_clamped = BBCL_INTEG_MIN[31:0];
        end
        else
        begin
            integ_clamped = integ_sum[31:0];
        end
    end

    // Next values of all registers.
    always_comb
    begin
        angle_next     = angle_reg;
        tilt_next      = tilt_reg;
        yaw_next       = yaw_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        spdt_next      = spdt_reg;
        turnt_next     = turnt_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        num_abs_next   = num_abs_reg;
        num_neg_next   = num_neg_reg;
        off_next       = off_reg;
        filt_next      = filt_reg;
        integ_next     = integ_reg;
        bal_stage_next = bal_stage_reg;
        spd_stage_next = spd_stage_reg;
        trn_stage_next = trn_stage_reg;
        bal_out_next   = bal_out_reg;
        spd_out_next   = spd_out_reg;
        trn_out_next   = trn_out_reg;
        off_out_next   = off_out_reg;
        out_valid_next = out_valid_reg;

        // Input capture.
        if (ctrl.capture)
        begin
            angle_next = angle;
            tilt_next  = tilt_rate;
            yaw_next   = yaw_rate;
            left_next  = left_count;
            right_next = right_count;
            spdt_next  = speed_target;
            turnt_next = turn_target;
        end

        // Shared multiplier.
        if (ctrl.mul_en)
        begin
            prod_next = prod_full;
        end

        // Accumulator.
        case (ctrl.acc_op)
            ACC_HOLD:     acc_next = acc_reg;
            ACC_LOAD:     acc_next = prod_ext;
            ACC_ADD:      acc_next = acc_reg + prod_ext;
            ACC_ADD_SHL8: acc_next = acc_reg + (prod_ext <<< 8);
            ACC_SUB:      acc_next = acc_reg - prod_ext;
            ACC_ROUND:    acc_next = acc_reg + (acc_reg[BBCL_ACC_W-1] ? round_mask : '0);
            default:      acc_next = acc_reg;
        endcase

        // Filter numerator and tilt check.
        if (ctrl.filt_prep)
        begin
            num_neg_next = num[33];
            num_abs_next = num_mag[31:0];
            off_next     = abs_angle > {1'b0, cfg.tilt_limit};
        end

        if (ctrl.filt_div)
        begin
            filt_next = num_neg_reg ? -quot : quot;
        end

        // Integral: update, and clear after the speed term on a tilt-over.
        if (ctrl.integ_upd)
        begin
            integ_next = integ_clamped;
        end
        else if (ctrl.integ_clr && off_reg)
        begin
            integ_next = '0;
        end

        // Finished drive terms.
        if (ctrl.write_term)
        begin
            case (ctrl.term)
                TERM_BAL: bal_stage_next = term_sat;
                TERM_SPD: spd_stage_next = term_sat;
                TERM_TRN: trn_stage_next = term_sat;
                default:  bal_stage_next = bal_stage_reg;
            endcase
        end

        // Output register: a word leaves when taken, a new one enters on commit.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.out_load)
        begin
            bal_out_next   = bal_stage_reg;
            spd_out_next   = spd_stage_reg;
            trn_out_next   = trn_stage_reg;
            off_out_next   = off_reg;
            out_valid_next = 1'b1;
        end
    end

    // Loop state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filt_reg      <= filt_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        angle_reg     <= angle_next;
        tilt_reg      <= tilt_next;
        yaw_reg       <= yaw_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        spdt_reg      <= spdt_next;
        turnt_reg     <= turnt_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        num_abs_reg   <= num_abs_next;
        num_neg_reg   <= num_neg_next;
        off_reg       <= off_next;
        bal_stage_reg <= bal_stage_next;
        spd_stage_reg <= spd_stage_next;
        trn_stage_reg <= trn_stage_next;
        bal_out_reg   <= bal_out_next;
        spd_out_reg   <= spd_out_next;
        trn_out_reg   <= trn_out_next;
        off_out_reg   <= off_out_next;
    end

    assign out_busy      = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign balance_drive = bal_out_reg;
    assign speed_drive   = spd_out_reg;
    assign turn_drive    = trn_out_reg;
    assign motors_off    = off_out_reg;

endmodule

/* sv/balance_robot_cascade_loops_top.sv */
// Balance robot controller: one input word per control tick gives one output word with
// the balance PD term, the speed PI term, the turn PD term and the motors-off flag. A
// microprogram of 13 steps after the idle step runs every term and the speed filter
// through one shared 33x33-bit multiplier and an accumulator. A result is committed in the
// last step, after which the sequencer returns to the idle step and the next word can be
// accepted; a new word is not taken while the previous one is worked on. A finished
// result waits in the output register while the next word is already being worked on;
// only the final commit waits for that register to drain. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce; indexes beyond the eight
// registers are ignored.
module balance_robot_cascade_loops_top
    import bbcl_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = BBCL_GAIN_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [BBCL_CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [16:0]        angle,
    input  logic signed [15:0]        tilt_rate,
    input  logic signed [15:0]        yaw_rate,
    input  logic signed [15:0]        left_count,
    input  logic signed [15:0]        right_count,
    input  logic signed [15:0]        speed_target,
    input  logic signed [15:0]        turn_target,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [31:0]        balance_drive,
    output logic signed [31:0]        speed_drive,
    output logic signed [31:0]        turn_drive,
    output logic                      motors_off
);

    bbcl_cfg_t  cfg_reg;
    bbcl_cfg_t  cfg_next;
    bbcl_ctrl_t ctrl;
    logic       idle;
    logic       out_busy;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BAL_KP:         cfg_next.bal_kp         = cfg_data;
                CFG_BAL_KD:         cfg_next.bal_kd         = cfg_data;
                CFG_SPEED_KP:       cfg_next.speed_kp       = cfg_data;
                CFG_SPEED_KI:       cfg_next.speed_ki       = cfg_data;
                CFG_TURN_KP:        cfg_next.turn_kp        = cfg_data;
                CFG_TURN_KD:        cfg_next.turn_kd        = cfg_data;
                CFG_BALANCE_OFFSET: cfg_next.balance_offset = cfg_data[16:0];
                CFG_TILT_LIMIT:     cfg_next.tilt_limit     = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bal_kp         <= RST_BAL_KP;
            cfg_reg.bal_kd         <= RST_BAL_KD;
            cfg_reg.speed_kp       <= RST_SPEED_KP;
            cfg_reg.speed_ki       <= RST_SPEED_KI;
            cfg_reg.turn_kp        <= RST_TURN_KP;
            cfg_reg.turn_kd        <= RST_TURN_KD;
            cfg_reg.balance_offset <= RST_BALANCE_OFFSET;
            cfg_reg.tilt_limit     <= RST_TILT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input words are taken only in the idle step.
    assign in_stall = ~idle;

    // Microcode sequencer.
    bbcl_useq u_useq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .idle     (idle),
        .ctrl     (ctrl)
    );

    // Arithmetic datapath with loop state and output register.
    bbcl_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .angle         (angle),
        .tilt_rate     (tilt_rate),
        .yaw_rate      (yaw_rate),
        .left_count    (left_count),
        .right_count   (right_count),
        .speed_target  (speed_target),
        .turn_target   (turn_target),
        .out_stall     (out_stall),
        .out_busy      (out_busy),
        .out_valid     (out_valid),
        .balance_drive (balance_drive),
        .speed_drive   (speed_drive),
        .turn_drive    (turn_drive),
        .motors_off    (motors_off)
    );

endmodule
